// ===== sv/sha1_pkg.sv =====
// Shared types, constants and helper functions for the SHA-1 digest block.
package sha1_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 5;
    localparam int ROUNDS      = 80;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_WB,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    // working variables a..e of the compression
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
    } work_vars_t;

    function automatic logic [WORD_W-1:0] h_init(input logic [2:0] idx);
        logic [WORD_W-1:0] val;
        case (idx)
            3'd0:    val = 32'h67452301;
            3'd1:    val = 32'hEFCDAB89;
            3'd2:    val = 32'h98BADCFE;
            3'd3:    val = 32'h10325476;
            3'd4:    val = 32'hC3D2E1F0;
            default: val = '0;
        endcase
        return val;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [6:0] rnd);
        logic [WORD_W-1:0] val;
        if (rnd < 7'd20)
            val = 32'h5A827999;
        else if (rnd < 7'd40)
            val = 32'h6ED9EBA1;
        else if (rnd < 7'd60)
            val = 32'h8F1BBCDC;
        else
            val = 32'hCA62C1D6;
        return val;
    endfunction

endpackage

// ===== sv/sha1_ram.sv =====
// Single-clock RAM, one write port and one registered read port.
module sha1_ram #(
    parameter int DEPTH = sha1_pkg::BLOCK_WORDS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [sha1_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [sha1_pkg::WORD_W-1:0] rdata
);

    logic [sha1_pkg::WORD_W-1:0] mem [DEPTH];
    logic [sha1_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sha1_round.sv =====
// One SHA-1 compression round: f select, round constant and the five-term add.
module sha1_round (
    input  sha1_pkg::work_vars_t        vars,
    input  logic [sha1_pkg::WORD_W-1:0] w,
    input  logic [6:0]                  rnd,
    output sha1_pkg::work_vars_t        vars_out
);

    logic [sha1_pkg::WORD_W-1:0] f;
    logic [sha1_pkg::WORD_W-1:0] t;

    always_comb
    begin
        if (rnd < 7'd20)
            f = (vars.b & vars.c) | (~vars.b & vars.d);
        else if (rnd < 7'd40)
            f = vars.b ^ vars.c ^ vars.d;
        else if (rnd < 7'd60)
            f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
        else
            f = vars.b ^ vars.c ^ vars.d;

        t = {vars.a[26:0], vars.a[31:27]} + f + vars.e + w + sha1_pkg::round_k(rnd);

        vars_out.a = t;
        vars_out.b = vars.a;
        vars_out.c = {vars.b[1:0], vars.b[31:2]};
        vars_out.d = vars.c;
        vars_out.e = vars.d;
    end

endmodule

// ===== sv/sha1_message_digest.sv =====
// SHA-1 streaming hasher: control FSM, byte packing, schedule and hash update.
// Absorb: a byte is taken each time data_valid is seen while idle; the 64th byte of a block
// starts a compression (hash load, 80 rounds, hash write-back), one round per cycle.
// Finish: 1..16 padding writes and one compression, or 16 more writes and a
// second compression when the length spills; then five words, each held through any stall.
// Reset: asynchronous, active low; the hash RAM reads as the initial values
// until the first write-back, so no clearing pass is needed.
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    // control state
    sha1_pkg::state_t state_reg, state_next;
    logic [6:0]  round_reg, round_next;     // round, load/write-back step or digest word
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] byte_cnt_reg, byte_cnt_next;
    logic        fresh_reg, fresh_next;     // hash RAM still at initial values
    logic        pad_mode_reg, pad_mode_next;
    logic        len_ok_reg, len_ok_next;   // current padding block carries the length
    logic        first_pad_reg, first_pad_next;
    logic        digest_valid_reg, digest_valid_next;

    // payload
    logic [23:0]              acc_reg, acc_next;
    sha1_pkg::work_vars_t     vars_reg, vars_next;
    logic [31:0]              sched_reg [sha1_pkg::BLOCK_WORDS];
    logic                     sched_shift;
    logic [31:0]              w_t;
    logic [31:0]              w_exp;
    logic [31:0]              digest_word_reg, digest_word_next;
    logic [2:0]               word_index_reg, word_index_next;
    logic                     last_word_reg, last_word_next;
    logic [2:0]               hr_addr_reg;

    // memory ports
    logic        bram_we;
    logic [3:0]  bram_waddr, bram_raddr;
    logic [31:0] bram_wdata, bram_rdata;
    logic        hram_we;
    logic [2:0]  hram_waddr, hram_raddr;
    logic [31:0] hram_wdata, hram_rdata;

    logic [31:0]          hval;
    logic [31:0]          first_word;
    logic [63:0]          bit_count;
    sha1_pkg::work_vars_t round_out;

    // message block: 16 words, written by packing/padding, read by the rounds
    sha1_ram #(
        .DEPTH (sha1_pkg::BLOCK_WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (bram_we),
        .waddr (bram_waddr),
        .wdata (bram_wdata),
        .raddr (bram_raddr),
        .rdata (bram_rdata)
    );

    // chaining value H0..H4
    sha1_ram #(
        .DEPTH (sha1_pkg::HASH_WORDS)
    ) u_hash_ram (
        .clk   (clk),
        .we    (hram_we),
        .waddr (hram_waddr),
        .wdata (hram_wdata),
        .raddr (hram_raddr),
        .rdata (hram_rdata)
    );

    sha1_round u_round (
        .vars     (vars_reg),
        .w        (w_t),
        .rnd      (round_reg),
        .vars_out (round_out)
    );

    // the hash RAM reads as the initial values until the first write-back
    assign hval = fresh_reg ? sha1_pkg::h_init(hr_addr_reg) : hram_rdata;

    assign bit_count = {byte_cnt_reg, 3'b000};

    // schedule taps: sched_reg[i] holds W[t-16+i]
    assign w_exp = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign w_t   = (round_reg < 7'd16) ? bram_rdata : {w_exp[30:0], w_exp[31]};

    // word that holds the 0x80 marker after the pending bytes
    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    first_word = {sha1_pkg::PAD_BYTE, 24'h0};
            2'd1:    first_word = {acc_reg[7:0], sha1_pkg::PAD_BYTE, 16'h0};
            2'd2:    first_word = {acc_reg[15:0], sha1_pkg::PAD_BYTE, 8'h0};
            default: first_word = {acc_reg[23:0], sha1_pkg::PAD_BYTE};
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        round_next        = round_reg;
        pad_idx_next      = pad_idx_reg;
        pos_next          = pos_reg;
        byte_cnt_next     = byte_cnt_reg;
        fresh_next        = fresh_reg;
        pad_mode_next     = pad_mode_reg;
        len_ok_next       = len_ok_reg;
        first_pad_next    = first_pad_reg;
        digest_valid_next = digest_valid_reg;
        acc_next          = acc_reg;
        vars_next         = vars_reg;
        digest_word_next  = digest_word_reg;
        word_index_next   = word_index_reg;
        last_word_next    = last_word_reg;
        sched_shift       = 1'b0;

        bram_we    = 1'b0;
        bram_waddr = pos_reg[5:2];
        bram_wdata = '0;
        bram_raddr = '0;
        hram_we    = 1'b0;
        hram_waddr = '0;
        hram_wdata = '0;
        hram_raddr = '0;

        data_stall = (state_reg != sha1_pkg::ST_IDLE);

        case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (data_valid)
                begin
                    if (!kind)
                    begin
                        acc_next      = {acc_reg[15:0], data_byte};
                        pos_next      = pos_reg + 6'd1;
                        byte_cnt_next = byte_cnt_reg + 61'd1;
                        // a word is complete on its fourth byte
                        if (pos_reg[1:0] == 2'd3)
                        begin
                            bram_we    = 1'b1;
                            bram_wdata = {acc_reg, data_byte};
                        end
                        if (pos_reg == 6'd63)
                        begin
                            pad_mode_next = 1'b0;
                            round_next    = '0;
                            state_next    = sha1_pkg::ST_LOAD;
                        end
                    end
                    else
                    begin
                        pad_idx_next   = pos_reg[5:2];
                        first_pad_next = 1'b1;
                        len_ok_next    = (pos_reg[5:2] < 4'd14);
                        pad_mode_next  = 1'b1;
                        state_next     = sha1_pkg::ST_PAD;
                    end
                end
            end

            sha1_pkg::ST_PAD:
            begin
                bram_we    = 1'b1;
                bram_waddr = pad_idx_reg;
                if (first_pad_reg)
                    bram_wdata = first_word;
                else if (len_ok_reg && pad_idx_reg == 4'd14)
                    bram_wdata = bit_count[63:32];
                else if (len_ok_reg && pad_idx_reg == 4'd15)
                    bram_wdata = bit_count[31:0];
                else
                    bram_wdata = '0;
                first_pad_next = 1'b0;
                if (pad_idx_reg == 4'd15)
                begin
                    round_next = '0;
                    state_next = sha1_pkg::ST_LOAD;
                end
                else
                begin
                    pad_idx_next = pad_idx_reg + 4'd1;
                end
            end

            sha1_pkg::ST_LOAD:
            begin
                if (round_reg < 7'd5)
                    hram_raddr = round_reg[2:0];
                if (round_reg != 7'd0)
                    vars_next = {vars_reg.b, vars_reg.c, vars_reg.d, vars_reg.e, hval};
                if (round_reg == 7'd5)
                begin
                    bram_raddr = '0;
                    round_next = '0;
                    state_next = sha1_pkg::ST_ROUND;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end

            sha1_pkg::ST_ROUND:
            begin
                vars_next   = round_out;
                sched_shift = 1'b1;
                bram_raddr  = round_reg[3:0] + 4'd1;
                if (round_reg == 7'(sha1_pkg::ROUNDS - 1))
                begin
                    round_next = '0;
                    state_next = sha1_pkg::ST_WB;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end

            sha1_pkg::ST_WB:
            begin
                if (round_reg < 7'd5)
                    hram_raddr = round_reg[2:0];
                if (round_reg != 7'd0)
                begin
                    hram_we    = 1'b1;
                    hram_waddr = round_reg[2:0] - 3'd1;
                    hram_wdata = hval + vars_reg.a;
                    vars_next  = {vars_reg.b, vars_reg.c, vars_reg.d, vars_reg.e, vars_reg.a};
                end
                if (round_reg == 7'd5)
                begin
                    fresh_next = 1'b0;
                    round_next = '0;
                    if (!pad_mode_reg)
                        state_next = sha1_pkg::ST_IDLE;
                    else if (len_ok_reg)
                        state_next = sha1_pkg::ST_OUT_RD;
                    else
                    begin
                        // padding spilled over: a second block with the length
                        len_ok_next  = 1'b1;
                        pad_idx_next = '0;
                        state_next   = sha1_pkg::ST_PAD;
                    end
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end

            sha1_pkg::ST_OUT_RD:
            begin
                hram_raddr = round_reg[2:0];
                state_next = sha1_pkg::ST_OUT_LD;
            end

            sha1_pkg::ST_OUT_LD:
            begin
                digest_word_next  = hval;
                word_index_next   = round_reg[2:0];
                last_word_next    = (round_reg == 7'd4);
                digest_valid_next = 1'b1;
                state_next        = sha1_pkg::ST_OUT_WAIT;
            end

            sha1_pkg::ST_OUT_WAIT:
            begin
                if (!digest_stall)
                begin
                    digest_valid_next = 1'b0;
                    if (round_reg == 7'd4)
                    begin
                        fresh_next    = 1'b1;
                        pos_next      = '0;
                        byte_cnt_next = '0;
                        round_next    = '0;
                        state_next    = sha1_pkg::ST_IDLE;
                    end
                    else
                    begin
                        round_next = round_reg + 7'd1;
                        state_next = sha1_pkg::ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sha1_pkg::ST_IDLE;
            round_reg        <= '0;
            pad_idx_reg      <= '0;
            pos_reg          <= '0;
            byte_cnt_reg     <= '0;
            fresh_reg        <= 1'b1;
            pad_mode_reg     <= 1'b0;
            len_ok_reg       <= 1'b0;
            first_pad_reg    <= 1'b0;
            digest_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            round_reg        <= round_next;
            pad_idx_reg      <= pad_idx_next;
            pos_reg          <= pos_next;
            byte_cnt_reg     <= byte_cnt_next;
            fresh_reg        <= fresh_next;
            pad_mode_reg     <= pad_mode_next;
            len_ok_reg       <= len_ok_next;
            first_pad_reg    <= first_pad_next;
            digest_valid_reg <= digest_valid_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        vars_reg        <= vars_next;
        digest_word_reg <= digest_word_next;
        word_index_reg  <= word_index_next;
        last_word_reg   <= last_word_next;
        hr_addr_reg     <= hram_raddr;
        if (sched_shift)
        begin
            for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[sha1_pkg::BLOCK_WORDS-1] <= w_t;
        end
    end

    assign digest_valid = digest_valid_reg;
    assign digest_word  = digest_word_reg;
    assign word_index   = word_index_reg;
    assign last_word    = last_word_reg;

endmodule

// ===== sv/sha1_md_checker.sv =====
// Port-level checker for the SHA-1 digest block, bound to the top level.
module sha1_md_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        data_stall,
    input logic        digest_valid,
    input logic        digest_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest_word)
            && $stable(word_index))
        else $error("digest word changed while stalled");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (word_index <= 3'd4) && (last_word == (word_index == 3'd4)))
        else $error("bad word index or last flag");

    // no byte is taken while the digest is being emitted
    a_no_input_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> data_stall)
        else $error("input taken during digest output");

    // word order: after a non-final transfer the next word is one higher
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && !last_word |=> !digest_valid ##2
            (digest_valid && word_index == $past(word_index, 3) + 3'd1))
        else $error("digest words out of order");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && last_word |=> !digest_valid)
        else $error("output after last digest word");

endmodule

bind sha1_message_digest sha1_md_checker u_sha1_md_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_stall   (data_stall),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
);
